[src/cpid_pkg.sv]
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared types, constants and the control store of the cascaded
// position/speed PID.
// ----------------------------------------------------------------------------
package cpid_pkg;

  localparam int FLOW_W = 16;
  localparam int GAIN_W = 16;
  localparam int CMD_W  = 14;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 48;
  localparam int ERR_W  = 17;
  localparam int PI_W   = 28;
  localparam int OUT_W  = 29;
  localparam int SE_W   = 22;
  localparam int SI_W   = 22;
  localparam int Q_W    = 30;
  localparam int DQ_W   = 37;
  localparam int PC_W   = 5;

  // Q16.16 limits
  localparam logic signed [ACC_W-1:0] POS_I_LIM = 48'sd131072000;
  localparam logic signed [ACC_W-1:0] POS_O_LIM = 48'sd196608000;
  localparam logic signed [ACC_W-1:0] SPD_I_LIM = 48'sd1310720;
  localparam logic signed [ACC_W-1:0] SPD_O_LIM = 48'sd1966080;
  localparam logic [FLOW_W-1:0]       THR_MIN   = 16'd100;

  // Reciprocals for divide by constant: q0 = (n * K) >> S, then one fixup
  localparam logic [MUL_W-1:0] K_DIV10  = 32'd419430;
  localparam logic [MUL_W-1:0] K_DIV125 = 32'd137438953;
  localparam logic [MUL_W-1:0] K_DIV100 = 32'd171798691;
  localparam int S_DIV10  = 22;
  localparam int S_DIV1XX = 34;

  typedef enum logic [CFG_AW-1:0] {
    CFG_POS_KP = 3'd0,
    CFG_POS_KI = 3'd1,
    CFG_POS_KD = 3'd2,
    CFG_SPD_KP = 3'd3,
    CFG_SPD_KI = 3'd4,
    CFG_SPD_KD = 3'd5,
    CFG_HOLD_X = 3'd6,
    CFG_HOLD_Y = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_10,
    DIV_125,
    DIV_100
  } dsel_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LD_POS,
    OP_DMUL,
    OP_DFIX,
    OP_WR_POS,
    OP_M_PI,
    OP_AC_PI,
    OP_ZERO_PI,
    OP_M_PP,
    OP_AC_SET,
    OP_M_PD,
    OP_AC_OUT,
    OP_LD_V,
    OP_LD_SE,
    OP_M_SI,
    OP_AC_SI,
    OP_M_SP,
    OP_AC_ADD,
    OP_M_SD,
    OP_AC_CMD
  } op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_NLOW,
    JMP_AXIS,
    JMP_END
  } jmp_t;

  typedef struct packed {
    op_t             op;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic ax;
  } dp_ctl_t;

  localparam logic AX_ROLL  = 1'b0;
  localparam logic AX_PITCH = 1'b1;

  localparam logic [PC_W-1:0] PC_AXIS = 5'd0;
  localparam logic [PC_W-1:0] PC_PP   = 5'd7;

  // Control store: one axis program, run for roll then pitch, then emit.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{OP_NOP, JMP_END, PC_AXIS};
    case (pc)
      5'd0:  w = '{OP_LD_POS,  JMP_NONE, PC_AXIS};
      5'd1:  w = '{OP_DMUL,    JMP_NONE, PC_AXIS};
      5'd2:  w = '{OP_DFIX,    JMP_NONE, PC_AXIS};
      5'd3:  w = '{OP_WR_POS,  JMP_NONE, PC_AXIS};
      5'd4:  w = '{OP_M_PI,    JMP_NONE, PC_AXIS};
      5'd5:  w = '{OP_AC_PI,   JMP_NLOW, PC_PP};
      5'd6:  w = '{OP_ZERO_PI, JMP_NONE, PC_AXIS};
      5'd7:  w = '{OP_M_PP,    JMP_NONE, PC_AXIS};
      5'd8:  w = '{OP_AC_SET,  JMP_NONE, PC_AXIS};
      5'd9:  w = '{OP_M_PD,    JMP_NONE, PC_AXIS};
      5'd10: w = '{OP_AC_OUT,  JMP_NONE, PC_AXIS};
      5'd11: w = '{OP_LD_V,    JMP_NONE, PC_AXIS};
      5'd12: w = '{OP_DMUL,    JMP_NONE, PC_AXIS};
      5'd13: w = '{OP_DFIX,    JMP_NONE, PC_AXIS};
      5'd14: w = '{OP_LD_SE,   JMP_NONE, PC_AXIS};
      5'd15: w = '{OP_DMUL,    JMP_NONE, PC_AXIS};
      5'd16: w = '{OP_DFIX,    JMP_NONE, PC_AXIS};
      5'd17: w = '{OP_M_SI,    JMP_NONE, PC_AXIS};
      5'd18: w = '{OP_AC_SI,   JMP_NONE, PC_AXIS};
      5'd19: w = '{OP_M_SP,    JMP_NONE, PC_AXIS};
      5'd20: w = '{OP_AC_ADD,  JMP_NONE, PC_AXIS};
      5'd21: w = '{OP_M_SD,    JMP_NONE, PC_AXIS};
      5'd22: w = '{OP_AC_CMD,  JMP_AXIS, PC_AXIS};
      5'd23: w = '{OP_NOP,     JMP_END,  PC_AXIS};
      default: w = '{OP_NOP,   JMP_END,  PC_AXIS};
    endcase
    return w;
  endfunction

endpackage

[src/cpid_in_if.sv]
// ----------------------------------------------------------------------------
// cpid_in_if
// Input channel: flow and throttle item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpid_in_if import cpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [FLOW_W-1:0] flow_x;
  logic signed [FLOW_W-1:0] flow_y;
  logic [FLOW_W-1:0]        throttle;

  modport source (output valid, flow_x, flow_y, throttle, input ready);
  modport sink   (input valid, flow_x, flow_y, throttle, output ready);
endinterface

[src/cpid_out_if.sv]
// ----------------------------------------------------------------------------
// cpid_out_if
// Result channel: roll and pitch commands with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpid_out_if import cpid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] roll_cmd;
  logic signed [CMD_W-1:0] pitch_cmd;

  modport source (output valid, roll_cmd, pitch_cmd, input ready);
  modport sink   (input valid, roll_cmd, pitch_cmd, output ready);
endinterface

[src/cpid_dpath.sv]
// ----------------------------------------------------------------------------
// cpid_dpath
// Datapath of the PID sequencer: config registers, per-axis loop state,
// one shared multiplier, divide-by-constant fixup and the accumulator.
// ----------------------------------------------------------------------------
module cpid_dpath import cpid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [CFG_DW-1:0]        cfg_wdata,
  input  logic                     ld,
  input  logic signed [FLOW_W-1:0] flow_x,
  input  logic signed [FLOW_W-1:0] flow_y,
  input  logic [FLOW_W-1:0]        throttle,
  input  logic                     en,
  input  dp_ctl_t                  ctl,
  output logic                     low_thr,
  output logic signed [CMD_W-1:0]  roll_cmd,
  output logic signed [CMD_W-1:0]  pitch_cmd
);

  function automatic logic signed [ACC_W-1:0] clamp_acc(
    input logic signed [ACC_W-1:0] x,
    input logic signed [ACC_W-1:0] lim
  );
    logic signed [ACC_W-1:0] y;
    y = x;
    if (x > lim) begin
      y = lim;
    end else if (x < -lim) begin
      y = -lim;
    end
    return y;
  endfunction

  // divide by 256, truncating toward zero
  function automatic logic signed [ACC_W-1:0] trunc256(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] b;
    b = x[ACC_W-1] ? x + ACC_W'(255) : x;
    return b >>> 8;
  endfunction

  // config
  logic [GAIN_W-1:0]        pos_kp_r, pos_ki_r, pos_kd_r;
  logic [GAIN_W-1:0]        spd_kp_r, spd_ki_r, spd_kd_r;
  logic signed [FLOW_W-1:0] hold_x_r, hold_y_r;

  // item
  logic signed [FLOW_W-1:0] flow_x_r, flow_y_r;
  logic                     low_r;

  // per-axis state
  logic signed [FLOW_W-1:0] pos_r   [2];
  logic signed [PI_W-1:0]   pi_r    [2];
  logic signed [ERR_W-1:0]  le_r    [2];
  logic signed [SI_W-1:0]   si_r    [2];
  logic signed [SE_W:0]     lse_r   [2];
  logic signed [CMD_W-1:0]  cmd_r   [2];

  // scratch
  logic [Q_W-1:0]           mag_r;
  logic                     neg_r;
  dsel_t                    dsel_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [31:0]       res_r;
  logic signed [ERR_W-1:0]  e_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [OUT_W-1:0]  out_r;

  logic                     ax;
  logic signed [FLOW_W-1:0] flow_sel;
  logic signed [FLOW_W-1:0] hold_sel;
  logic signed [20:0]       px;
  logic signed [20:0]       pos_x10;
  logic signed [33:0]       ld_val;
  logic [Q_W-1:0]           mag_nxt;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [Q_W-1:0]           q0, q_fix;
  logic [DQ_W-1:0]          dq, rem, dval;
  logic signed [31:0]       res_nxt;
  logic signed [FLOW_W-1:0] pos_nxt;
  logic signed [ERR_W-1:0]  e_nxt;
  logic signed [ACC_W-1:0]  prod_sh8, prod_t;
  logic signed [ACC_W-1:0]  pi_nxt, out_nxt, si_nxt, cmd_sum;
  logic signed [ACC_W-1:0]  cmd_full;

  assign ax       = ctl.ax;
  assign flow_sel = (ax == AX_PITCH) ? flow_x_r : flow_y_r;
  assign hold_sel = (ax == AX_PITCH) ? hold_x_r : hold_y_r;

  assign px      = 21'(pos_r[ax]);
  assign pos_x10 = (px <<< 3) + (px <<< 1) + 21'(flow_sel);

  // dividend for the next divide-by-constant
  always_comb begin
    case (ctl.op)
      OP_LD_POS: ld_val = 34'(pos_x10);
      OP_LD_V:   ld_val = 34'(flow_sel) <<< 13;
      OP_LD_SE:  ld_val = 34'(res_r) - 34'(out_r);
      default:   ld_val = '0;
    endcase
  end

  always_comb begin
    logic signed [33:0] a;
    a       = ld_val[33] ? -ld_val : ld_val;
    mag_nxt = a[Q_W-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    case (ctl.op)
      OP_DMUL: begin
        case (dsel_r)
          DIV_10:  mul_a = K_DIV10;
          DIV_125: mul_a = K_DIV125;
          DIV_100: mul_a = K_DIV100;
          default: mul_a = '0;
        endcase
        mul_b = MUL_W'(mag_r);
      end
      OP_M_PI: begin
        mul_a = MUL_W'(pos_ki_r);
        mul_b = MUL_W'(e_r);
      end
      OP_M_PP: begin
        mul_a = MUL_W'(pos_kp_r);
        mul_b = MUL_W'(e_r);
      end
      OP_M_PD: begin
        mul_a = MUL_W'(pos_kd_r);
        mul_b = MUL_W'(e_r) - MUL_W'(le_r[ax]);
      end
      OP_M_SI: begin
        mul_a = MUL_W'(spd_ki_r);
        mul_b = res_r;
      end
      OP_M_SP: begin
        mul_a = MUL_W'(spd_kp_r);
        mul_b = res_r;
      end
      OP_M_SD: begin
        mul_a = MUL_W'(spd_kd_r);
        mul_b = res_r - MUL_W'(lse_r[ax]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  // reciprocal estimate is at most one low; one compare-subtract fixes it
  always_comb begin
    case (dsel_r)
      DIV_10: begin
        q0   = prod_r[S_DIV10 +: Q_W];
        dq   = (DQ_W'(q0) << 3) + (DQ_W'(q0) << 1);
        dval = DQ_W'(10);
      end
      DIV_125: begin
        q0   = prod_r[S_DIV1XX +: Q_W];
        dq   = (DQ_W'(q0) << 7) - (DQ_W'(q0) << 2) + DQ_W'(q0);
        dval = DQ_W'(125);
      end
      DIV_100: begin
        q0   = prod_r[S_DIV1XX +: Q_W];
        dq   = (DQ_W'(q0) << 6) + (DQ_W'(q0) << 5) + (DQ_W'(q0) << 2);
        dval = DQ_W'(100);
      end
      default: begin
        q0   = '0;
        dq   = '0;
        dval = DQ_W'(1);
      end
    endcase
    rem     = DQ_W'(mag_r) - dq;
    q_fix   = (rem >= dval) ? q0 + Q_W'(1) : q0;
    res_nxt = neg_r ? -$signed(32'(q_fix)) : $signed(32'(q_fix));
  end

  // saturate the dead-reckoned position, then form the position error
  always_comb begin
    if (res_r > 32'sd32767) begin
      pos_nxt = 16'sh7FFF;
    end else if (res_r < -32'sd32768) begin
      pos_nxt = 16'sh8000;
    end else begin
      pos_nxt = res_r[FLOW_W-1:0];
    end
    e_nxt = ERR_W'(hold_sel) - ERR_W'(pos_nxt);
  end

  assign prod_sh8 = {prod_r[ACC_W-9:0], 8'b0};
  assign prod_t   = trunc256(prod_r[ACC_W-1:0]);
  assign pi_nxt   = clamp_acc(ACC_W'(pi_r[ax]) + prod_sh8, POS_I_LIM);
  assign out_nxt  = clamp_acc(acc_r + prod_sh8, POS_O_LIM);
  assign si_nxt   = clamp_acc(ACC_W'(si_r[ax]) + prod_t, SPD_I_LIM);
  assign cmd_sum  = clamp_acc(acc_r + prod_t, SPD_O_LIM);
  assign cmd_full = trunc256(cmd_sum);

  // config, item and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_kp_r <= '0;
      pos_ki_r <= '0;
      pos_kd_r <= '0;
      spd_kp_r <= '0;
      spd_ki_r <= '0;
      spd_kd_r <= '0;
      hold_x_r <= '0;
      hold_y_r <= '0;
      low_r    <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        pos_r[i] <= '0;
        pi_r[i]  <= '0;
        le_r[i]  <= '0;
        si_r[i]  <= '0;
        lse_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_POS_KP: pos_kp_r <= cfg_wdata;
          CFG_POS_KI: pos_ki_r <= cfg_wdata;
          CFG_POS_KD: pos_kd_r <= cfg_wdata;
          CFG_SPD_KP: spd_kp_r <= cfg_wdata;
          CFG_SPD_KI: spd_ki_r <= cfg_wdata;
          CFG_SPD_KD: spd_kd_r <= cfg_wdata;
          CFG_HOLD_X: hold_x_r <= cfg_wdata;
          CFG_HOLD_Y: hold_y_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (ld) begin
        low_r <= (throttle < THR_MIN);
      end
      if (en) begin
        case (ctl.op)
          OP_WR_POS:  pos_r[ax] <= pos_nxt;
          OP_AC_PI:   pi_r[ax]  <= pi_nxt[PI_W-1:0];
          OP_ZERO_PI: pi_r[ax]  <= '0;
          OP_M_PD:    le_r[ax]  <= e_r;
          OP_AC_SI:   si_r[ax]  <= si_nxt[SI_W-1:0];
          OP_M_SD:    lse_r[ax] <= res_r[SE_W:0];
          default: ;
        endcase
      end
    end
  end

  // scratch and payload
  always_ff @(posedge clk) begin
    if (ld) begin
      flow_x_r <= flow_x;
      flow_y_r <= flow_y;
    end
    if (en) begin
      case (ctl.op)
        OP_LD_POS: begin
          mag_r  <= mag_nxt;
          neg_r  <= ld_val[33];
          dsel_r <= DIV_10;
        end
        OP_LD_V: begin
          mag_r  <= mag_nxt;
          neg_r  <= ld_val[33];
          dsel_r <= DIV_125;
        end
        OP_LD_SE: begin
          mag_r  <= mag_nxt;
          neg_r  <= ld_val[33];
          dsel_r <= DIV_100;
        end
        OP_DMUL, OP_M_PI, OP_M_PP, OP_M_PD, OP_M_SI, OP_M_SP, OP_M_SD: begin
          prod_r <= prod_nxt;
        end
        OP_DFIX:   res_r    <= res_nxt;
        OP_WR_POS: e_r      <= e_nxt;
        OP_AC_SET: acc_r    <= prod_sh8 + ACC_W'(pi_r[ax]);
        OP_AC_OUT: out_r    <= out_nxt[OUT_W-1:0];
        OP_AC_SI:  acc_r    <= si_nxt;
        OP_AC_ADD: acc_r    <= acc_r + prod_t;
        OP_AC_CMD: cmd_r[ax] <= cmd_full[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  assign low_thr   = low_r;
  assign roll_cmd  = cmd_r[AX_ROLL];
  assign pitch_cmd = cmd_r[AX_PITCH];

endmodule

[src/cascaded_position_speed_pid.sv]
// ----------------------------------------------------------------------------
// cascaded_position_speed_pid
// Optical-flow position hold: outer position PID feeding an inner speed PID
// per axis, roll on y and pitch on x, commands out in Q6.8.
// ----------------------------------------------------------------------------
// A microcoded sequencer runs a 24-step control store through one shared
// 32x32 multiplier, one product per step. When throttle is below 100, the
// integrator clear step also runs on both axes. A new item is taken in the
// cycle after the result is loaded, never while one is being worked on. The
// result sits in an output register; if it has not been taken by the time
// the next result is ready, the sequencer waits on its last step.
// Configuration writes take effect at once and belong between items.
module cascaded_position_speed_pid import cpid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  cpid_in_if.sink           in_ch,
  cpid_out_if.source        out_ch
);

  logic                    busy_r;
  logic [PC_W-1:0]         pc_r;
  logic                    ax_r;
  logic                    out_valid_r;
  logic signed [CMD_W-1:0] out_roll_r;
  logic signed [CMD_W-1:0] out_pitch_r;

  uword_t                  uw;
  dp_ctl_t                 ctl;
  logic                    accept;
  logic                    emit_stall;
  logic                    step_en;
  logic                    low_thr;
  logic signed [CMD_W-1:0] roll_cmd;
  logic signed [CMD_W-1:0] pitch_cmd;
  logic [PC_W-1:0]         pc_nxt;

  assign uw         = ucode(pc_r);
  assign in_ch.ready = rst_n && !busy_r;
  assign accept     = in_ch.valid && in_ch.ready;
  assign emit_stall = (uw.jmp == JMP_END) && out_valid_r && !out_ch.ready;
  assign step_en    = busy_r && !emit_stall;

  assign ctl = '{op: uw.op, ax: ax_r};

  always_comb begin
    pc_nxt = pc_r + PC_W'(1);
    case (uw.jmp)
      JMP_NLOW: if (!low_thr) begin
        pc_nxt = uw.target;
      end
      JMP_AXIS: if (ax_r == AX_ROLL) begin
        pc_nxt = uw.target;
      end
      JMP_END:  pc_nxt = PC_AXIS;
      JMP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_AXIS;
      ax_r        <= AX_ROLL;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        pc_r   <= PC_AXIS;
        ax_r   <= AX_ROLL;
      end else if (step_en) begin
        pc_r <= pc_nxt;
        if (uw.jmp == JMP_AXIS && ax_r == AX_ROLL) begin
          ax_r <= AX_PITCH;
        end
        if (uw.jmp == JMP_END) begin
          busy_r <= 1'b0;
        end
      end
      if (step_en && uw.jmp == JMP_END) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && uw.jmp == JMP_END) begin
      out_roll_r  <= roll_cmd;
      out_pitch_r <= pitch_cmd;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.roll_cmd  = out_roll_r;
  assign out_ch.pitch_cmd = out_pitch_r;

  cpid_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .ld        (accept),
    .flow_x    (in_ch.flow_x),
    .flow_y    (in_ch.flow_y),
    .throttle  (in_ch.throttle),
    .en        (step_en),
    .ctl       (ctl),
    .low_thr   (low_thr),
    .roll_cmd  (roll_cmd),
    .pitch_cmd (pitch_cmd)
  );

endmodule
